// ----- design/hmbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbp_pkg: shared types and constants of the hash message block padder.
// Request formats, the register map, controller commands and datapath status.
// ----------------------------------------------------------------------------
package hmbp_pkg;

  // Block geometry.
  localparam int unsigned MAX_BLOCK_BYTES   = 128;
  localparam int unsigned SMALL_BLOCK_BYTES = 64;
  localparam int unsigned LEN_BYTES_SMALL   = 8;
  localparam int unsigned LEN_BYTES_LARGE   = 16;

  // Field widths fixed by the interface.
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned WORD_INDEX_W  = 4;
  localparam int unsigned COUNT_LOW_W   = 64;
  localparam int unsigned COUNT_HIGH_W  = 61;

  // Byte appended after the last message byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Register port.
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BLOCK_SIZE_SEL = 1'b0
  } reg_idx_t;

  // Request operation codes.
  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // Input request: one message byte or a finish command.
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } msg_t;

  // Output request: one 64-bit word of a block.
  typedef struct packed {
    logic [WORD_W-1:0]       block_word;
    logic [WORD_INDEX_W-1:0] word_index;
    logic                    first_block;
    logic                    final_block;
    logic                    last;
  } word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input request taken this cycle
    logic load;      // capture the composed word into the output register
    logic advance;   // output word taken, step to the next word of the block
    logic next_blk;  // extra block done, start the final length block
    logic done;      // last word taken, close the block or the message
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;        // the offered request causes block output
    logic last_word;   // current word is the last of its block
    logic extra_pend;  // a final length block still follows
  } dp_sts_t;

endpackage

// ----- design/hmbp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbp_ram: generic single-write, single-read RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hmbp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/hmbp_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbp_dpath: datapath of the message block padder.
// Packs bytes into words in the block buffer, keeps the byte count, and
// composes output words with the pad byte, zero fill and bit length.
// ----------------------------------------------------------------------------
module hmbp_dpath #(
  parameter int unsigned MAX_BYTES = hmbp_pkg::MAX_BLOCK_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sel,
  input  hmbp_pkg::msg_t     msg,
  input  hmbp_pkg::ctrl_cmd_t cmd,
  output hmbp_pkg::dp_sts_t  sts,
  output hmbp_pkg::word_t    word
);

  localparam int unsigned FILL_W = $clog2(MAX_BYTES);
  localparam int unsigned WORDS  = MAX_BYTES / 8;
  localparam int unsigned WA_W   = $clog2(WORDS);
  localparam int unsigned IDX_W  = hmbp_pkg::WORD_INDEX_W;
  localparam int unsigned CLO_W  = hmbp_pkg::COUNT_LOW_W;
  localparam int unsigned CHI_W  = hmbp_pkg::COUNT_HIGH_W;
  localparam int unsigned WW     = hmbp_pkg::WORD_W;

  localparam logic [FILL_W:0] BLK_LARGE = (FILL_W+1)'(MAX_BYTES);
  localparam logic [FILL_W:0] BLK_SMALL = (FILL_W+1)'(hmbp_pkg::SMALL_BLOCK_BYTES);
  localparam logic [FILL_W:0] LEN_LARGE = (FILL_W+1)'(hmbp_pkg::LEN_BYTES_LARGE);
  localparam logic [FILL_W:0] LEN_SMALL = (FILL_W+1)'(hmbp_pkg::LEN_BYTES_SMALL);

  // Message state.
  logic [FILL_W-1:0] fill;
  logic [CLO_W-1:0]  cnt_lo;
  logic [CHI_W-1:0]  cnt_hi;
  logic              started;
  logic [WW-1:0]     word_acc;

  // Block emission context.
  logic [WA_W-1:0]   wa;
  logic [FILL_W-1:0] ctx_dl;
  logic [7:0]        ctx_mark;
  logic              ctx_mark_en;
  logic              ctx_final;
  logic              ctx_finish;
  logic              extra_pend;

  logic [FILL_W:0]   blk_bytes;
  logic [FILL_W:0]   blk_m1;
  logic [FILL_W:0]   len_bytes;
  logic [FILL_W-1:0] last_idx;
  logic [FILL_W-1:0] fill_used;
  logic              completes;
  logic              needs_extra;
  logic              is_data;
  logic [WA_W-1:0]   last_wa;
  logic [WA_W-1:0]   hi_wa;
  logic [WW-1:0]     acc_merged;
  logic [WW-1:0]     composed;
  logic [WW-1:0]     rd_word;
  logic [WA_W-1:0]   raddr;
  logic              ram_we;
  logic [2*WW-1:0]   bit_len;

  // Block geometry for the selected size.
  assign blk_bytes = sel ? BLK_LARGE : BLK_SMALL;
  assign len_bytes = sel ? LEN_LARGE : LEN_SMALL;
  assign blk_m1    = blk_bytes - 1'b1;
  assign last_idx  = blk_m1[FILL_W-1:0];
  assign last_wa   = last_idx[FILL_W-1:3];
  assign hi_wa     = last_wa - 1'b1;

  // A fill left beyond the block by a size change lands on the last byte.
  assign fill_used   = ({1'b0, fill} >= blk_bytes) ? last_idx : fill;
  assign completes   = (fill_used == last_idx);
  assign needs_extra = ({1'b0, fill_used} >= (blk_bytes - len_bytes));
  assign is_data     = (msg.op == hmbp_pkg::OP_DATA);

  // Message bit length, byte count times eight.
  assign bit_len = {cnt_hi, cnt_lo, 3'b000};

  // Status toward the controller.
  assign sts.emit       = !is_data || completes;
  assign sts.last_word  = (wa == last_wa);
  assign sts.extra_pend = extra_pend;

  // Insert the new byte into its lane of the partial word.
  always_comb begin
    acc_merged = word_acc;
    for (int k = 0; k < 8; k++) begin
      if (fill[2:0] == k[2:0]) begin
        acc_merged[8*(7-k) +: 8] = msg.data_byte;
      end
    end
  end

  // A byte that completes the block is not stored; the composer supplies it.
  assign ram_we = cmd.accept && is_data && !completes;
  assign raddr  = cmd.advance ? (wa + 1'b1) : '0;

  hmbp_ram #(
    .WIDTH (WW),
    .DEPTH (WORDS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[FILL_W-1:3]),
    .wdata (acc_merged),
    .raddr (raddr),
    .rdata (rd_word)
  );

  // Compose one output word: stored bytes, marker byte, zeros, then length.
  always_comb begin
    logic [FILL_W-1:0] pos;
    composed = '0;
    pos      = '0;
    for (int k = 0; k < 8; k++) begin
      pos = {wa, k[2:0]};
      if (pos < ctx_dl) begin
        composed[8*(7-k) +: 8] = rd_word[8*(7-k) +: 8];
      end else if (ctx_mark_en && (pos == ctx_dl)) begin
        composed[8*(7-k) +: 8] = ctx_mark;
      end
    end
    if (ctx_final && (wa == last_wa)) begin
      composed = bit_len[WW-1:0];
    end else if (ctx_final && sel && (wa == hi_wa)) begin
      composed = bit_len[2*WW-1:WW];
    end
  end

  // Message state and emission context.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      cnt_lo      <= '0;
      cnt_hi      <= '0;
      started     <= 1'b0;
      wa          <= '0;
      extra_pend  <= 1'b0;
      ctx_final   <= 1'b0;
      ctx_finish  <= 1'b0;
      ctx_mark_en <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (is_data) begin
          cnt_lo <= cnt_lo + 1'b1;
          if (&cnt_lo) begin
            cnt_hi <= cnt_hi + 1'b1;
          end
          if (!completes) begin
            fill <= fill + 1'b1;
          end
        end
        if (sts.emit) begin
          wa          <= '0;
          ctx_mark_en <= 1'b1;
          ctx_finish  <= !is_data;
          extra_pend  <= !is_data && needs_extra;
          ctx_final   <= !is_data && !needs_extra;
        end
      end
      if (cmd.advance) begin
        wa <= wa + 1'b1;
      end
      // The extra block is out; the next one holds only zeros and length.
      if (cmd.next_blk) begin
        wa          <= '0;
        ctx_mark_en <= 1'b0;
        ctx_final   <= 1'b1;
        extra_pend  <= 1'b0;
        started     <= 1'b1;
      end
      if (cmd.done) begin
        fill <= '0;
        if (ctx_finish) begin
          cnt_lo  <= '0;
          cnt_hi  <= '0;
          started <= 1'b0;
        end else begin
          started <= 1'b1;
        end
      end
    end
  end

  // Partial word, marker and data limit need no reset.
  always_ff @(posedge clk) begin
    if (ram_we) begin
      word_acc <= acc_merged;
    end
    if (cmd.accept && sts.emit) begin
      ctx_dl   <= fill_used;
      ctx_mark <= is_data ? msg.data_byte : hmbp_pkg::PAD_BYTE;
    end
    if (cmd.next_blk) begin
      ctx_dl <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word.block_word  <= composed;
      word.word_index  <= IDX_W'(wa);
      word.first_block <= !started;
      word.final_block <= ctx_final;
      word.last        <= sts.last_word && !extra_pend;
    end
  end

endmodule

// ----- design/hmbp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbp_ctrl: controller of the message block padder.
// Takes requests while idle and steps the datapath through block output.
// ----------------------------------------------------------------------------
module hmbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_ready,
  output logic                word_valid,
  input  logic                word_ready,
  input  hmbp_pkg::dp_sts_t   sts,
  output hmbp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign msg_ready  = (state == S_IDLE);
  assign word_valid = (state == S_WAIT);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = msg_valid;
        if (msg_valid && sts.emit) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (word_ready) begin
          if (!sts.last_word) begin
            cmd.advance = 1'b1;
            state_next  = S_LOAD;
          end else if (sts.extra_pend) begin
            cmd.next_blk = 1'b1;
            state_next   = S_LOAD;
          end else begin
            cmd.done   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One request at a time: no input is taken while a word is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    msg_ready |-> !word_valid)
    else $error("input taken while an output word is pending");

  // A request that causes output offers its first word once the load state has passed.
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && msg_ready && sts.emit) |=> ##1 word_valid)
    else $error("first output word not offered on time");

  // Taking the last word of the last block returns the controller to idle.
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (word_valid && word_ready && sts.last_word && !sts.extra_pend) |=> msg_ready)
    else $error("controller did not return to idle after the last word");

endmodule

// ----- design/hash_message_block_padder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_message_block_padder: SHA-2 style message padding front end.
// Collects message bytes into blocks and emits padded 64-bit block words.
// ----------------------------------------------------------------------------
// Usage:
//   The msg channel carries one request per byte (op = data) or a finish
//   request. A data byte that does not fill the block is taken and the
//   block stays ready. A byte that fills the block, or a finish, starts
//   block output on the word channel: 8 words for a 64-byte block, 16 for
//   a 128-byte block, twice that when the length needs an extra block.
//   Each word, the first one included, is read from the block buffer with
//   a registered read and then composed in the output register before it
//   is offered; the next word is read only once the previous one is taken.
//   No new request is taken until the last word (last = 1) is taken, so a
//   stalled receiver holds the whole block. The block size is to be set
//   through the register port only while idle; the block itself does not
//   enforce it. Reset clears the fill count, byte count, first-block flag
//   and block size; buffer contents are left as they are and are never
//   read before being written.
// ----------------------------------------------------------------------------
module hash_message_block_padder #(
  parameter int unsigned MAX_BLOCK_BYTES = hmbp_pkg::MAX_BLOCK_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         msg_valid,
  output logic                         msg_ready,
  input  hmbp_pkg::msg_t               msg,
  output logic                         word_valid,
  input  logic                         word_ready,
  output hmbp_pkg::word_t              word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hmbp_pkg::PADDR_W-1:0] paddr,
  input  logic [hmbp_pkg::PDATA_W-1:0] pwdata,
  output logic [hmbp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic                block_size_sel;
  logic                reg_hit;
  hmbp_pkg::ctrl_cmd_t cmd;
  hmbp_pkg::dp_sts_t   sts;

  // Register decode.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[hmbp_pkg::PADDR_W-1:2] == hmbp_pkg::REG_BLOCK_SIZE_SEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_sel <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      block_size_sel <= pwdata[0];
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[0] = block_size_sel;
    end
  end

  hmbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hmbp_dpath #(
    .MAX_BYTES (MAX_BLOCK_BYTES)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .sel  (block_size_sel),
    .msg  (msg),
    .cmd  (cmd),
    .sts  (sts),
    .word (word)
  );

endmodule
